/* rtl/ewd_pkg.sv */
// ----------------------------------------------------------------------------
// ewd_pkg
// shared types, character codes and lookup functions of the encoded word
// decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ewd_pkg;

  localparam int QUEUE_DEPTH = 4;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // character codes
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_Q_UP  = 8'h51;
  localparam logic [7:0] CH_Q_LO  = 8'h71;
  localparam logic [7:0] CH_B_UP  = 8'h42;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [2:0] SEG_MAX    = 3'd7;
  localparam logic [2:0] SEG_LETTER = 3'd2;
  localparam logic [2:0] SEG_TEXT   = 3'd3;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_Q    = 2'd1,
    MODE_B    = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } entry_t;

  // up to three results caused by one input transaction
  typedef struct packed {
    logic [1:0]       cnt;
    entry_t [2:0]     ent;
  } bundle_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        hex_val = {1'b1, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
        hex_val = {1'b1, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
        hex_val = {1'b1, d[3:0]};
      end else begin
        hex_val = {1'b0, d[3:0]};
      end
    end
  endfunction

  // {valid, value}
  function automatic logic [6:0] b64_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41;
        b64_val = {1'b1, d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        d = c - 8'h47;
        b64_val = {1'b1, d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d = c + 8'h04;
        b64_val = {1'b1, d[5:0]};
      end else if (c == CH_PLUS) begin
        b64_val = {1'b1, 6'd62};
      end else if (c == CH_SLASH) begin
        b64_val = {1'b1, 6'd63};
      end else begin
        b64_val = {1'b0, d[5:0]};
      end
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/ewd_front.sv */
// ----------------------------------------------------------------------------
// ewd_front
// accepts raw bytes, tracks segments and text mode, decodes q and b text and
// packs the results of each transaction into one queue entry
// ----------------------------------------------------------------------------
`default_nettype none

module ewd_front
  import ewd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_word_end,
  input  wire logic       q_full,
  output logic            q_push,
  output bundle_t         q_bundle
);

  logic [2:0] seg_r, seg_nxt;
  mode_t      mode_r, mode_nxt;
  logic       lt_r, lt_nxt;
  logic       bad_r, bad_nxt;
  logic [1:0] hc_r, hc_nxt;
  logic [7:0] h1_r, h1_nxt;
  logic [7:0] bb_r, bb_nxt;
  logic [2:0] bo_r, bo_nxt;
  logic       pad_r, pad_nxt;

  logic       accept;
  logic [1:0] n;
  bundle_t    bnd;
  logic [4:0] hx;
  logic [4:0] hx_held;
  logic [6:0] bv;
  logic [2:0] k;
  logic [3:0] sh;
  logic [7:0] c;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_byte;
  assign hx       = hex_val(c);
  assign hx_held  = hex_val(h1_r);
  assign bv       = b64_val(c);
  assign k        = 3'(bo_r - 3'd2);
  assign sh       = 4'd8 - {1'b0, k};

  always_comb begin
    seg_nxt  = seg_r;
    mode_nxt = mode_r;
    lt_nxt   = lt_r;
    bad_nxt  = bad_r;
    hc_nxt   = hc_r;
    h1_nxt   = h1_r;
    bb_nxt   = bb_r;
    bo_nxt   = bo_r;
    pad_nxt  = pad_r;
    n        = 2'd0;
    bnd      = '0;

    if (!bad_r) begin
      if (c == CH_QMARK) begin
        if (seg_r == SEG_LETTER && mode_r != MODE_Q && mode_r != MODE_B) begin
          bad_nxt = 1'b1;
        end
        if (seg_r == SEG_TEXT && mode_r == MODE_Q) begin
          // text cut off: held bytes pass literally
          if (hc_nxt != 2'd0) begin
            bnd.ent[n] = '{data: CH_EQ, kind: KIND_DATA};
            n = n + 2'd1;
          end
          if (hc_nxt[1]) begin
            bnd.ent[n] = '{data: h1_nxt, kind: KIND_DATA};
            n = n + 2'd1;
          end
          hc_nxt = 2'd0;
        end
        if (seg_r < SEG_MAX) begin
          seg_nxt = seg_r + 3'd1;
        end
      end else if (seg_r == SEG_LETTER) begin
        if (!lt_r) begin
          lt_nxt = 1'b1;
          if (c == CH_Q_UP || c == CH_Q_LO) begin
            mode_nxt = MODE_Q;
          end else if (c == CH_B_UP || c == CH_B_LO) begin
            mode_nxt = MODE_B;
          end else begin
            mode_nxt = MODE_BAD;
          end
        end
      end else if (seg_r == SEG_TEXT) begin
        if (mode_r == MODE_Q) begin
          if (hc_r == 2'd0) begin
            if (c == CH_EQ) begin
              hc_nxt = 2'd1;
            end else begin
              bnd.ent[n] = '{data: (c == CH_USCORE) ? CH_SPACE : c, kind: KIND_DATA};
              n = n + 2'd1;
            end
          end else if (hc_r == 2'd1) begin
            if (hx[4]) begin
              h1_nxt = c;
              hc_nxt = 2'd2;
            end else begin
              // lone '=' passes, byte handled fresh
              hc_nxt = 2'd0;
              bnd.ent[n] = '{data: CH_EQ, kind: KIND_DATA};
              n = n + 2'd1;
              if (c == CH_EQ) begin
                hc_nxt = 2'd1;
              end else begin
                bnd.ent[n] = '{data: (c == CH_USCORE) ? CH_SPACE : c, kind: KIND_DATA};
                n = n + 2'd1;
              end
            end
          end else begin
            hc_nxt = 2'd0;
            if (hx[4]) begin
              bnd.ent[n] = '{data: {hx_held[3:0], hx[3:0]}, kind: KIND_DATA};
              n = n + 2'd1;
            end else begin
              bnd.ent[n] = '{data: CH_EQ, kind: KIND_DATA};
              n = n + 2'd1;
              bnd.ent[n] = '{data: h1_r, kind: KIND_DATA};
              n = n + 2'd1;
              // a non-hex final byte is dropped
              if (!in_word_end) begin
                if (c == CH_EQ) begin
                  hc_nxt = 2'd1;
                end else begin
                  bnd.ent[n] = '{data: (c == CH_USCORE) ? CH_SPACE : c, kind: KIND_DATA};
                  n = n + 2'd1;
                end
              end
            end
          end
        end else if (mode_r == MODE_B && !pad_r) begin
          if (c == CH_EQ) begin
            pad_nxt = 1'b1;
          end else if (bv[6]) begin
            if (bo_r >= 3'd2) begin
              bnd.ent[n] = '{data: bb_r | ({2'b00, bv[5:0]} >> k), kind: KIND_DATA};
              n = n + 2'd1;
              bb_nxt = 8'({2'b00, bv[5:0]} << sh);
              bo_nxt = k;
            end else begin
              bb_nxt = bb_r | 8'({2'b00, bv[5:0]} << 3'(bo_r + 3'd2));
              bo_nxt = 3'(bo_r + 3'd6);
            end
          end
        end
      end
    end

    if (in_word_end) begin
      if (!bad_nxt) begin
        if (hc_nxt != 2'd0) begin
          bnd.ent[n] = '{data: CH_EQ, kind: KIND_DATA};
          n = n + 2'd1;
        end
        if (hc_nxt[1]) begin
          bnd.ent[n] = '{data: h1_nxt, kind: KIND_DATA};
          n = n + 2'd1;
        end
      end
      bnd.ent[n] = '{data: 8'h00, kind: bad_nxt ? KIND_BAD : KIND_OK};
      n = n + 2'd1;
      seg_nxt  = '0;
      mode_nxt = MODE_NONE;
      lt_nxt   = 1'b0;
      bad_nxt  = 1'b0;
      hc_nxt   = '0;
      h1_nxt   = '0;
      bb_nxt   = '0;
      bo_nxt   = '0;
      pad_nxt  = 1'b0;
    end
    bnd.cnt = n;
  end

  assign q_push   = accept && (n != 2'd0);
  assign q_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= '0;
      mode_r <= MODE_NONE;
      lt_r   <= 1'b0;
      bad_r  <= 1'b0;
      hc_r   <= '0;
      h1_r   <= '0;
      bb_r   <= '0;
      bo_r   <= '0;
      pad_r  <= 1'b0;
    end else if (accept) begin
      seg_r  <= seg_nxt;
      mode_r <= mode_nxt;
      lt_r   <= lt_nxt;
      bad_r  <= bad_nxt;
      hc_r   <= hc_nxt;
      h1_r   <= h1_nxt;
      bb_r   <= bb_nxt;
      bo_r   <= bo_nxt;
      pad_r  <= pad_nxt;
    end
  end

  // base64 bit offset only ever holds an even count below eight
  a_bo_even: assert property (@(posedge clk) disable iff (!rst_n) !bo_r[0])
    else $error("ewd_front: odd base64 bit offset");

  // a held digit is only possible in q text
  a_held_q: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 2'd0) |-> (mode_r == MODE_Q && seg_r == SEG_TEXT))
    else $error("ewd_front: held bytes outside q text");

endmodule

`default_nettype wire

/* rtl/ewd_queue.sv */
// ----------------------------------------------------------------------------
// ewd_queue
// small fifo of result bundles between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module ewd_queue
  import ewd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_bundle,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      head,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_bundle;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("ewd_queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("ewd_queue: pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(DEPTH))
    else $error("ewd_queue: count beyond depth");

endmodule

`default_nettype wire

/* rtl/ewd_back.sv */
// ----------------------------------------------------------------------------
// ewd_back
// walks the results of the head bundle one per cycle into the output register while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module ewd_back
  import ewd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire bundle_t head,
  input  wire logic    empty,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [7:0]   out_byte,
  output logic [1:0]   out_kind,
  output logic         out_final_flag
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  entry_t     ent_r;
  logic       load;
  logic       last_ent;

  assign load     = !vld_r || out_ready;
  assign last_ent = (idx_r == 2'(head.cnt - 2'd1));
  assign pop      = load && !empty && last_ent;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = !empty;
      if (!empty) begin
        idx_nxt = last_ent ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      ent_r <= head.ent[idx_r];
    end
  end

  assign out_valid      = vld_r;
  assign out_byte       = ent_r.data;
  assign out_kind       = ent_r.kind;
  assign out_final_flag = (ent_r.kind != KIND_DATA);

  // the entry pointer stays inside the head bundle
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (idx_r < head.cnt))
    else $error("ewd_back: entry index past bundle");

endmodule

`default_nettype wire

/* rtl/encoded_word_decoder_top.sv */
// ----------------------------------------------------------------------------
// encoded_word_decoder_top
// decodes the bytes of one mime header encoded word (=?charset?X?text?=)
// ----------------------------------------------------------------------------
// usage:
//   input channel takes one raw byte per transaction (in_byte), with
//   in_word_end high on the final byte of the word
//   result channel gives decoded bytes (out_kind data) and one end marker per
//   word (out_kind ok or bad letter) with out_final_flag set
//   a transaction may cause zero to three results; the front decodes it in
//   the cycle it is accepted and queues its results as one bundle
// path: the bundle is written to the queue at the accepting edge, and from
//   the queue the back loads its first result into the output register,
//   whose valid bit drives out_valid
// throughput: while out_ready stays high, one input transaction per cycle
//   while each causes at most one result; the single output register drains
//   one result per cycle, so a transaction with several results holds it until
//   all are out, and the bundle queue (QUEUE_DEPTH entries) absorbs such bursts
// reset: synchronous, active low; decode state and queue are cleared and no
//   result is valid
// stall: while out_ready is low the output holds; in_ready drops only once
//   the bundle queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module encoded_word_decoder_top
  import ewd_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_word_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_final_flag
);

  // front to queue
  logic    q_push;
  bundle_t q_bundle;
  logic    q_full;

  // queue to back
  bundle_t q_head;
  logic    q_empty;
  logic    q_pop;

  // segment tracking, q and b decode
  ewd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_word_end (in_word_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_bundle    (q_bundle)
  );

  // decouples decode from output stalls
  ewd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_bundle (q_bundle),
    .full        (q_full),
    .pop         (q_pop),
    .head        (q_head),
    .empty       (q_empty)
  );

  // serializes bundles onto the result channel
  ewd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_final_flag (out_final_flag)
  );

endmodule

`default_nettype wire
